// ===== src/prbd_pkg.sv =====
package prbd_pkg;

    localparam int BYTES_PER_RESULT = 8;
    localparam int ROW_WIDTH_BITS   = 16;
    localparam int BYTE_W           = 8;
    localparam int OUT_W            = BYTES_PER_RESULT * BYTE_W;
    localparam int COUNT_W          = 4;
    localparam int RUN_W            = 8;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [ROW_WIDTH_BITS-1:0] ROW_WIDTH_RESET = ROW_WIDTH_BITS'(64);
    localparam logic [BYTE_W-1:0]         REPEAT_BASE     = BYTE_W'(128);

    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_LITERAL = 3'b010,
        PH_REPEAT  = 3'b100
    } phase_t;

    // one expansion job: emit data byte run_len times
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [RUN_W-1:0]  run_len;
        logic              row_end;
        logic              clip;
    } cmd_t;

endpackage

// ===== src/prbd_front.sv =====
module prbd_front (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [prbd_pkg::BYTE_W-1:0]           s_in_byte,
    input  logic                                  cfg_valid,
    input  logic [prbd_pkg::ROW_WIDTH_BITS-1:0]   cfg_row_width,
    input  logic                                  q_full,
    output logic                                  q_push,
    output prbd_pkg::cmd_t                        q_cmd
);

    localparam int RW = prbd_pkg::ROW_WIDTH_BITS;
    localparam int BW = prbd_pkg::BYTE_W;

    prbd_pkg::phase_t  phase_reg, phase_next;
    logic [BW-1:0]     literal_left_reg, literal_left_next;
    logic [BW-1:0]     repeat_len_reg, repeat_len_next;
    logic [RW-1:0]     row_left_reg, row_left_next;
    logic              clip_reg, clip_next;
    logic [RW-1:0]     row_width_reg;

    logic              accept;
    logic [RW-1:0]     width_eff;
    logic [RW-1:0]     lit_row_left;
    logic [BW-1:0]     lit_left_dec;
    logic [RW-1:0]     rep_n;
    logic [RW-1:0]     rep_row_left;
    logic [BW-1:0]     hdr_lit_len;
    logic [BW-1:0]     hdr_rep_len;

    assign s_ready   = !q_full;
    assign accept    = s_valid && s_ready;
    assign width_eff = (row_width_reg == '0) ? RW'(1) : row_width_reg;

    assign lit_row_left = (row_left_reg != '0) ? row_left_reg - RW'(1) : row_left_reg;
    assign lit_left_dec = (literal_left_reg != '0) ? literal_left_reg - BW'(1)
                                                   : literal_left_reg;
    assign rep_n        = (RW'(repeat_len_reg) > row_left_reg) ? row_left_reg
                                                               : RW'(repeat_len_reg);
    assign rep_row_left = row_left_reg - rep_n;
    assign hdr_lit_len  = s_in_byte + BW'(1);
    // 257 - b fits in a byte for b >= 128
    assign hdr_rep_len  = BW'(9'd257 - {1'b0, s_in_byte});

    always_comb begin
        phase_next        = phase_reg;
        literal_left_next = literal_left_reg;
        repeat_len_next   = repeat_len_reg;
        row_left_next     = row_left_reg;
        clip_next         = clip_reg;
        q_push            = 1'b0;
        q_cmd             = '0;
        if (accept) begin
            case (phase_reg)
                prbd_pkg::PH_LITERAL: begin
                    q_push            = (row_left_reg != '0);
                    q_cmd.data        = s_in_byte;
                    q_cmd.run_len     = prbd_pkg::RUN_W'(1);
                    q_cmd.row_end     = (lit_row_left == '0);
                    q_cmd.clip        = clip_reg;
                    row_left_next     = lit_row_left;
                    literal_left_next = lit_left_dec;
                    if (lit_left_dec == '0) begin
                        phase_next = prbd_pkg::PH_HEADER;
                        if (lit_row_left == '0) begin
                            row_left_next = width_eff;
                        end
                    end
                end
                prbd_pkg::PH_REPEAT: begin
                    q_push          = (rep_n != '0);
                    q_cmd.data      = s_in_byte;
                    q_cmd.run_len   = prbd_pkg::RUN_W'(rep_n);
                    q_cmd.row_end   = (rep_row_left == '0);
                    q_cmd.clip      = clip_reg;
                    phase_next      = prbd_pkg::PH_HEADER;
                    repeat_len_next = '0;
                    row_left_next   = (rep_row_left == '0) ? width_eff : rep_row_left;
                end
                default: begin
                    if (s_in_byte < prbd_pkg::REPEAT_BASE) begin
                        literal_left_next = hdr_lit_len;
                        phase_next        = prbd_pkg::PH_LITERAL;
                        clip_next         = (RW'(hdr_lit_len) > row_left_reg);
                    end else begin
                        repeat_len_next = hdr_rep_len;
                        phase_next      = prbd_pkg::PH_REPEAT;
                        clip_next       = (RW'(hdr_rep_len) > row_left_reg);
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= prbd_pkg::PH_HEADER;
            literal_left_reg <= '0;
            repeat_len_reg   <= '0;
            row_left_reg     <= prbd_pkg::ROW_WIDTH_RESET;
            clip_reg         <= 1'b0;
            row_width_reg    <= prbd_pkg::ROW_WIDTH_RESET;
        end else begin
            phase_reg        <= phase_next;
            literal_left_reg <= literal_left_next;
            repeat_len_reg   <= repeat_len_next;
            row_left_reg     <= row_left_next;
            clip_reg         <= clip_next;
            if (cfg_valid) begin
                row_width_reg <= cfg_row_width;
            end
        end
    end

endmodule

// ===== src/prbd_cmd_fifo.sv =====
module prbd_cmd_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  prbd_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output prbd_pkg::cmd_t head
);

    localparam int PW = prbd_pkg::FIFO_PTR_W;
    localparam int CW = prbd_pkg::FIFO_CNT_W;

    prbd_pkg::cmd_t store_reg [prbd_pkg::FIFO_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  fill_reg, fill_next;
    logic           do_push, do_pop;

    assign full    = (fill_reg == CW'(prbd_pkg::FIFO_DEPTH));
    assign empty   = (fill_reg == '0);
    assign head    = store_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(prbd_pkg::FIFO_DEPTH - 1)) ? '0
                                                                         : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(prbd_pkg::FIFO_DEPTH - 1)) ? '0
                                                                         : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            fill_next = fill_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== src/prbd_back.sv =====
module prbd_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              q_empty,
    input  prbd_pkg::cmd_t                    q_head,
    output logic                              q_pop,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [prbd_pkg::OUT_W-1:0]        m_out_bytes,
    output logic [prbd_pkg::COUNT_W-1:0]      m_out_count,
    output logic                              m_row_end,
    output logic                              m_run_last,
    output logic                              m_overrun
);

    localparam int NW = prbd_pkg::RUN_W;
    localparam int BW = prbd_pkg::BYTE_W;

    logic                 busy_reg, busy_next;
    logic [NW-1:0]        rem_reg, rem_next;
    prbd_pkg::cmd_t       cur_reg;

    logic                 m_valid_reg;
    logic [prbd_pkg::OUT_W-1:0]   bytes_reg, bytes_next;
    logic [prbd_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                 row_end_reg, last_reg, ovr_reg;

    logic                 out_load;
    logic                 have_src;
    prbd_pkg::cmd_t       src;
    logic [NW-1:0]        src_n;
    logic [NW-1:0]        chunk;
    logic [NW-1:0]        left;

    assign out_load = !m_valid_reg || m_ready;
    assign have_src = busy_reg || !q_empty;
    assign src      = busy_reg ? cur_reg : q_head;
    assign src_n    = busy_reg ? rem_reg : q_head.run_len;
    assign chunk    = (src_n > NW'(prbd_pkg::BYTES_PER_RESULT)) ? NW'(prbd_pkg::BYTES_PER_RESULT)
                                                                : src_n;
    assign left     = src_n - chunk;
    assign q_pop    = out_load && !busy_reg && !q_empty;

    always_comb begin
        for (int i = 0; i < prbd_pkg::BYTES_PER_RESULT; i++) begin
            bytes_next[i*BW +: BW] = (NW'(i) < chunk) ? src.data : '0;
        end
        count_next = prbd_pkg::COUNT_W'(chunk);
        busy_next  = busy_reg;
        rem_next   = rem_reg;
        if (out_load && have_src) begin
            busy_next = (left != '0);
            rem_next  = left;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            rem_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            rem_reg  <= rem_next;
            if (out_load) begin
                m_valid_reg <= have_src;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_head;
        end
        if (out_load && have_src) begin
            bytes_reg   <= bytes_next;
            count_reg   <= count_next;
            last_reg    <= (left == '0);
            row_end_reg <= (left == '0) && src.row_end;
            ovr_reg     <= src.clip;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_bytes = bytes_reg;
    assign m_out_count = count_reg;
    assign m_row_end   = row_end_reg;
    assign m_run_last  = last_reg;
    assign m_overrun   = ovr_reg;

endmodule

// ===== src/packbits_row_decoder.sv =====
// channel   direction  beat payload                                   handshake
// s_        in         s_in_byte[7:0]                                 s_valid / s_ready
// m_        out        m_out_bytes[63:0] m_out_count[3:0] m_row_end   m_valid / m_ready
//                      m_run_last m_overrun
// cfg_      in         cfg_row_width[15:0]                            cfg_valid / cfg_ready
//
// Input side takes one compressed byte per cycle while the command queue has room.
// Each literal byte within the row makes one result beat; a repeat byte makes ceil(n/8)
// beats, one per cycle while m_ready allows, issued by the back-end expander, so long repeats
// fill the 4-entry queue and then hold s_ready low.
// Synchronous active-low reset on aresetn; row width returns to 64.
// m_valid/m_ready stall the back-end expander; the front keeps going until the queue fills.
module packbits_row_decoder (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [prbd_pkg::BYTE_W-1:0]          s_in_byte,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [prbd_pkg::OUT_W-1:0]           m_out_bytes,
    output logic [prbd_pkg::COUNT_W-1:0]         m_out_count,
    output logic                                 m_row_end,
    output logic                                 m_run_last,
    output logic                                 m_overrun,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [prbd_pkg::ROW_WIDTH_BITS-1:0]  cfg_row_width
);

    // front -> queue
    logic           q_push;
    prbd_pkg::cmd_t q_cmd;
    logic           q_full;
    // queue -> back
    logic           q_pop;
    logic           q_empty;
    prbd_pkg::cmd_t q_head;

    // register write is always taken; write it only while idle, the block does not check
    assign cfg_ready = 1'b1;

    // header parsing, row bookkeeping, clip detection
    prbd_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .cfg_valid     (cfg_valid),
        .cfg_row_width (cfg_row_width),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (q_cmd)
    );

    // decouples byte intake from run expansion
    prbd_cmd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head     (q_head)
    );

    // splits each command into beats of up to eight bytes
    prbd_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_empty     (q_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_bytes (m_out_bytes),
        .m_out_count (m_out_count),
        .m_row_end   (m_row_end),
        .m_run_last  (m_run_last),
        .m_overrun   (m_overrun)
    );

    // a row can only close on the final beat of a run
    a_row_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_row_end |-> m_run_last)
        else $error("row_end without run_last");

    // every beat but the last of a run is full
    a_full_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_run_last |->
            m_out_count == prbd_pkg::COUNT_W'(prbd_pkg::BYTES_PER_RESULT))
        else $error("short beat before end of run");

    // beat size within range
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_out_count != '0) &&
                    (m_out_count <= prbd_pkg::COUNT_W'(prbd_pkg::BYTES_PER_RESULT)))
        else $error("beat count out of range");

endmodule

// ===== test/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // ------------------------------------------------------------------
    // knobs
    // ------------------------------------------------------------------
    localparam int IDLE_PCT     = 37;     // chance per cycle that a side holds off
    localparam int DRAIN_CYCLES = 32;     // quiet time after the last result beat
    localparam int SETTLE_LIMIT = 20000;  // cycles allowed for one phase to drain

    // one result beat as the block should present it
    typedef struct packed {
        logic [prbd_pkg::OUT_W-1:0]   bytes;
        logic [prbd_pkg::COUNT_W-1:0] cnt;
        logic                         row_end;
        logic                         run_last;
        logic                         overrun;
    } beat_t;

    // ------------------------------------------------------------------
    // clock, reset and block ports; every input known from time zero
    // ------------------------------------------------------------------
    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_byte     = '0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [63:0] m_out_bytes;
    logic [3:0]  m_out_count;
    logic        m_row_end;
    logic        m_run_last;
    logic        m_overrun;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_row_width = '0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    packbits_row_decoder dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_bytes   (m_out_bytes),
        .m_out_count   (m_out_count),
        .m_row_end     (m_row_end),
        .m_run_last    (m_run_last),
        .m_overrun     (m_overrun),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_row_width (cfg_row_width)
    );

    // ------------------------------------------------------------------
    // shared testbench state
    // ------------------------------------------------------------------
    logic [7:0] packed_stream[$];  // compressed bytes waiting for the driver
    beat_t      decoded_q[$];      // decoded beats still owed by the block
    bit         steady = 1'b0;     // both sides run without holding off
    int         errors = 0;

    // decoder shadow: own copy of the row width and of the run state
    prbd_pkg::phase_t                    dec_phase;
    logic [prbd_pkg::RUN_W:0]            lit_left;   // literal bytes still to consume
    logic [prbd_pkg::RUN_W:0]            rep_len;    // pending repeat count, up to 129
    logic [prbd_pkg::ROW_WIDTH_BITS-1:0] row_left;
    logic [prbd_pkg::ROW_WIDTH_BITS-1:0] row_width_cfg;
    logic                                clipping;   // current run was cut at the row end

    task automatic flag_mismatch(input string msg);
        errors++;
        $display("MISMATCH @%0t ns: %s", $time, msg);
    endtask

    // a programmed width of zero behaves as a one-byte row
    function automatic logic [prbd_pkg::ROW_WIDTH_BITS-1:0] eff_width();
        return (row_width_cfg == '0) ? prbd_pkg::ROW_WIDTH_BITS'(1) : row_width_cfg;
    endfunction

    function automatic void reset_decoder();
        row_width_cfg = prbd_pkg::ROW_WIDTH_RESET;
        dec_phase     = prbd_pkg::PH_HEADER;
        lit_left      = '0;
        rep_len       = '0;
        row_left      = eff_width();
        clipping      = 1'b0;
    endfunction

    // Advance the shadow decoder by one compressed byte and queue the beats it owes.
    function automatic void expand_byte(input logic [7:0] b);
        beat_t bt;
        int    n;
        int    c;
        case (dec_phase)
            prbd_pkg::PH_LITERAL: begin
                // bytes past the row end are swallowed without a beat
                if (row_left != 0) begin
                    row_left    = row_left - 1'b1;
                    bt          = '0;
                    bt.bytes    = prbd_pkg::OUT_W'(b);
                    bt.cnt      = prbd_pkg::COUNT_W'(1);
                    bt.row_end  = (row_left == 0);
                    bt.run_last = 1'b1;
                    bt.overrun  = clipping;
                    decoded_q.push_back(bt);
                end
                if (lit_left != 0)
                    lit_left = lit_left - 1'b1;
                if (lit_left == 0) begin
                    dec_phase = prbd_pkg::PH_HEADER;
                    if (row_left == 0)
                        row_left = eff_width();
                end
            end
            prbd_pkg::PH_REPEAT: begin
                n = int'(rep_len);
                if (n > int'(row_left))
                    n = int'(row_left);
                row_left = row_left - prbd_pkg::ROW_WIDTH_BITS'(n);
                // pattern goes out up to eight copies per beat
                while (n > 0) begin
                    c  = (n > prbd_pkg::BYTES_PER_RESULT) ? prbd_pkg::BYTES_PER_RESULT : n;
                    bt = '0;
                    for (int i = 0; i < c; i++)
                        bt.bytes[prbd_pkg::BYTE_W*i +: prbd_pkg::BYTE_W] = b;
                    n          -= c;
                    bt.cnt      = prbd_pkg::COUNT_W'(c);
                    bt.row_end  = (n == 0) && (row_left == 0);
                    bt.run_last = (n == 0);
                    bt.overrun  = clipping;
                    decoded_q.push_back(bt);
                end
                dec_phase = prbd_pkg::PH_HEADER;
                rep_len   = '0;
                if (row_left == 0)
                    row_left = eff_width();
            end
            default: begin
                // header: no beat, just arm the next run
                if (b < prbd_pkg::REPEAT_BASE) begin
                    lit_left  = (prbd_pkg::RUN_W+1)'(b) + 1'b1;
                    dec_phase = prbd_pkg::PH_LITERAL;
                    clipping  = (lit_left > row_left);
                end else begin
                    rep_len   = (prbd_pkg::RUN_W+1)'(257) - (prbd_pkg::RUN_W+1)'(b);
                    dec_phase = prbd_pkg::PH_REPEAT;
                    clipping  = (rep_len > row_left);
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // driver: one compressed byte per beat, random hold-off between beats
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            // current beat gone (or none up): present the next or go quiet
            if (packed_stream.size() != 0 &&
                (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                s_in_byte <= packed_stream.pop_front();
                s_valid   <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: watches config and input beats to keep the shadow in step,
    // checks every result beat against the oldest owed one, throttles m_ready
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        beat_t want;
        if (!aresetn) begin
            reset_decoder();
            decoded_q.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                row_width_cfg = cfg_row_width;
            if (s_valid && s_ready)
                expand_byte(s_in_byte);
            if (m_valid && m_ready) begin
                if (decoded_q.size() == 0) begin
                    flag_mismatch($sformatf("unexpected beat bytes=%h count=%0d",
                                            m_out_bytes, m_out_count));
                end else begin
                    want = decoded_q.pop_front();
                    if (m_out_bytes !== want.bytes)
                        flag_mismatch($sformatf("out_bytes got %h want %h",
                                                m_out_bytes, want.bytes));
                    if (m_out_count !== want.cnt)
                        flag_mismatch($sformatf("out_count got %0d want %0d",
                                                m_out_count, want.cnt));
                    if (m_row_end !== want.row_end)
                        flag_mismatch($sformatf("row_end got %b want %b",
                                                m_row_end, want.row_end));
                    if (m_run_last !== want.run_last)
                        flag_mismatch($sformatf("run_last got %b want %b",
                                                m_run_last, want.run_last));
                    if (m_overrun !== want.overrun)
                        flag_mismatch($sformatf("overrun got %b want %b",
                                                m_overrun, want.overrun));
                end
            end
        end
        m_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------
    // sequencing helpers (stream loads happen at the falling edge, so the
    // driver never races the queue)
    // ------------------------------------------------------------------

    // Wait until the stream is used up and every owed beat has arrived, then give
    // the block time to retire bytes that owe nothing (headers, clipped literals).
    task automatic settle();
        int waited;
        waited = 0;
        do begin
            @(negedge aclk);
            waited++;
        end while ((packed_stream.size() != 0 || s_valid || decoded_q.size() != 0) &&
                   waited < SETTLE_LIMIT);
        if (decoded_q.size() != 0)
            flag_mismatch($sformatf("%0d beats never arrived", decoded_q.size()));
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Only called with the block idle; the shadow picks the value up in the monitor.
    task automatic write_row_width(input logic [15:0] w);
        @(posedge aclk);
        cfg_row_width <= w;
        cfg_valid     <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Mostly well-formed packets with random content; the rest are stray bytes
    // and literal packets cut short, so the next header is eaten as payload.
    task automatic queue_packets(input int n_items);
        int made;
        int roll;
        int len;
        made = 0;
        while (made < n_items) begin
            roll = $urandom_range(0, 99);
            if (roll < 80) begin
                if ($urandom_range(0, 1) == 1) begin
                    // literal packet, now and then a long one
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 128)
                                                       : $urandom_range(1, 8);
                    packed_stream.push_back(8'(len - 1));
                    repeat (len) packed_stream.push_back(8'($urandom));
                    made += len + 1;
                end else begin
                    packed_stream.push_back(8'($urandom_range(128, 255)));
                    packed_stream.push_back(8'($urandom));
                    made += 2;
                end
            end else if (roll < 90) begin
                // truncated literal packet
                len = $urandom_range(2, 8);
                packed_stream.push_back(8'(len - 1));
                repeat ($urandom_range(0, len - 1)) begin
                    packed_stream.push_back(8'($urandom));
                    made++;
                end
                made++;
            end else begin
                packed_stream.push_back(8'($urandom));
                made++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed, default 64-byte rows
        // single literal carrying 0xff, then a three-byte literal run
        packed_stream.push_back(8'h00); packed_stream.push_back(8'hFF);
        packed_stream.push_back(8'h02); packed_stream.push_back(8'h00);
        packed_stream.push_back(8'h5A); packed_stream.push_back(8'hA5);
        // shortest repeat (two copies)
        packed_stream.push_back(8'hFF); packed_stream.push_back(8'h3C);
        // exactly one full beat, then one byte into a second beat
        packed_stream.push_back(8'hF9); packed_stream.push_back(8'h81);
        packed_stream.push_back(8'hF8); packed_stream.push_back(8'h7E);
        // 128 copies clipped at the row end, then 0x80 (129 copies) over a fresh row
        packed_stream.push_back(8'h81); packed_stream.push_back(8'hC3);
        packed_stream.push_back(8'h80); packed_stream.push_back(8'h00);
        settle();

        // one-byte rows: nearly every run clips
        write_row_width(16'd1);
        queue_packets(8);
        settle();

        // zero width behaves as one
        write_row_width(16'd0);
        queue_packets(6);
        settle();

        // widest rows: row end practically never reached
        write_row_width(16'hFFFF);
        queue_packets(8);
        settle();

        // longest literal packet; the row in progress keeps the old width
        write_row_width(16'd100);
        packed_stream.push_back(8'h7F);
        repeat (128) packed_stream.push_back(8'($urandom));
        settle();

        // odd width, full-rate stretch on both sides
        write_row_width(16'd13);
        steady = 1'b1;
        queue_packets(12);
        settle();
        steady = 1'b0;

        // row of exactly one full beat
        write_row_width(16'd8);
        queue_packets(6);
        settle();

        write_row_width(16'($urandom_range(2, 300)));
        queue_packets(8);
        settle();

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // hard stop well past the slowest legal run
    initial begin
        #(5_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
